// ===== src/cwdm_pkg.sv =====
// ----------------------------------------------------------------------------
// cwdm_pkg: shared types and constants for the chopped window demodulator
// Register indexes, register reset values, the configuration bundle that
// goes to the front end, and the back end state encoding.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cwdm_pkg;

   // control register port
   localparam int CFG_BITS      = 9;
   localparam int CSR_ADDR_BITS = 2;

   localparam logic [CSR_ADDR_BITS-1:0] CSR_WINDOW_LEN = 2'd0;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_VALID_LEN  = 2'd1;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_START_SIGN = 2'd2;

   localparam logic [CFG_BITS-1:0] WINDOW_LEN_RST = 9'd4;
   localparam logic [CFG_BITS-1:0] VALID_LEN_RST  = 9'd2;
   localparam logic                START_SIGN_RST = 1'b0;

   // configuration as seen by the front end
   typedef struct packed {
      logic [CFG_BITS-1:0] window_len;
      logic [CFG_BITS-1:0] valid_len;
      logic                start_sign;
      logic                start_sign_wr;   // one-cycle pulse on a start_sign write
   } cwdm_cfg_type;

   // back end sequencer
   typedef enum logic [2:0] {
      BK_IDLE,
      BK_MUL,
      BK_PREP,
      BK_DIV,
      BK_SAT,
      BK_OUT
   } cwdm_back_state_type;

endpackage

// ===== src/cwdm_queue.sv =====
// ----------------------------------------------------------------------------
// cwdm_queue: two-entry frame queue
// Flop-based FIFO that holds finished frame sums between the front end and
// the divider back end, so that either side can stall on its own.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cwdm_queue #(
   parameter int WIDTH = 60
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             pop_valid,
   output logic [WIDTH-1:0] pop_data
);

   logic [WIDTH-1:0] entry_ff [2];
   logic             wr_ptr_ff;
   logic             rd_ptr_ff;
   logic [1:0]       count_ff;
   logic             do_push;
   logic             do_pop;

   assign full      = (count_ff == 2'd2);
   assign pop_valid = (count_ff != 2'd0);
   assign pop_data  = entry_ff[rd_ptr_ff];
   assign do_push   = push_valid && !full;
   assign do_pop    = pop && pop_valid;

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (do_push) wr_ptr_ff <= ~wr_ptr_ff;
         if (do_pop)  rd_ptr_ff <= ~rd_ptr_ff;
         case ({do_push, do_pop})
            2'b10:   count_ff <= count_ff + 2'd1;
            2'b01:   count_ff <= count_ff - 2'd1;
            default: count_ff <= count_ff;
         endcase
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) entry_ff[wr_ptr_ff] <= push_data;
   end

endmodule

// ===== src/cwdm_front.sv =====
// ----------------------------------------------------------------------------
// cwdm_front: sample front end
// Tracks window position and sign, accumulates the valid tail of every
// window and folds closed windows into the frame difference. On the last
// sample of a frame it pushes the frame sum, window count and valid length.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cwdm_front #(
   parameter int SAMPLE_BITS = 16,
   parameter int WINDOW_BITS = 8,
   parameter int FRAME_BITS  = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  cwdm_pkg::cwdm_cfg_type           cfg,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic signed [SAMPLE_BITS-1:0]    req_sample,
   input  logic                             req_last_sample,
   output logic                             push_valid,
   output logic [SAMPLE_BITS+FRAME_BITS+2+FRAME_BITS+1
                 +((WINDOW_BITS+1 > cwdm_pkg::CFG_BITS) ? WINDOW_BITS+1
                                                       : cwdm_pkg::CFG_BITS)-1:0]
                                            push_data,
   input  logic                             push_full
);

   localparam int ACC_BITS  = SAMPLE_BITS + FRAME_BITS + 2;
   localparam int PART_BITS = SAMPLE_BITS + WINDOW_BITS + 1;
   localparam int SUM_BITS  = ((ACC_BITS > PART_BITS) ? ACC_BITS : PART_BITS) + 1;
   localparam int FW_BITS   = FRAME_BITS + 1;
   localparam int EW_BITS   = (WINDOW_BITS + 1 > cwdm_pkg::CFG_BITS) ? WINDOW_BITS + 1
                                                                    : cwdm_pkg::CFG_BITS;
   localparam logic [EW_BITS-1:0] WMAX = EW_BITS'(1) << WINDOW_BITS;
   localparam logic signed [ACC_BITS-1:0] ACC_MAX = {1'b0, {(ACC_BITS-1){1'b1}}};
   localparam logic signed [ACC_BITS-1:0] ACC_MIN = {1'b1, {(ACC_BITS-1){1'b0}}};

   logic [WINDOW_BITS-1:0]       pos_ff,  pos_in;
   logic                         sign_ff, sign_in;
   logic signed [ACC_BITS-1:0]   diff_ff, diff_in;
   logic [FW_BITS-1:0]           fw_ff,   fw_in;
   logic signed [PART_BITS-1:0]  part_ff, part_in;

   logic                         accept;
   logic [EW_BITS-1:0]           win_x, val_x, w_eff, v_eff, pos_x;
   logic                         use_smp, close_win, frame_empty;
   logic signed [PART_BITS-1:0]  samp_x, part_add;
   logic signed [SUM_BITS-1:0]   sum;
   logic                         ovf_pos, ovf_neg;
   logic signed [ACC_BITS-1:0]   diff_step;
   logic [FW_BITS-1:0]           fw_step;

   assign accept    = req_valid && !push_full;
   assign req_stall = push_full;

   // effective window and valid lengths
   assign win_x = EW_BITS'(cfg.window_len);
   assign val_x = EW_BITS'(cfg.valid_len);
   assign w_eff = (win_x == '0) ? EW_BITS'(1) : ((win_x > WMAX) ? WMAX : win_x);
   assign v_eff = (val_x > w_eff) ? w_eff : val_x;

   // classify the sample: settling or valid, window closing or not
   assign pos_x     = EW_BITS'(pos_ff);
   assign use_smp   = (pos_x >= (w_eff - v_eff));
   assign close_win = ((pos_x + EW_BITS'(1)) >= w_eff);

   // open-window accumulation
   assign samp_x   = PART_BITS'(req_sample);
   assign part_add = !use_smp ? part_ff
                   : (sign_ff ? (part_ff - samp_x) : (part_ff + samp_x));

   // fold into frame difference with saturation
   assign sum     = SUM_BITS'(diff_ff) + SUM_BITS'(part_add);
   assign ovf_pos = !sum[SUM_BITS-1] && (sum[SUM_BITS-2:ACC_BITS-1] != '0);
   assign ovf_neg =  sum[SUM_BITS-1] && (sum[SUM_BITS-2:ACC_BITS-1] != '1);

   always_comb begin
      if (!close_win) begin
         diff_step = diff_ff;
         fw_step   = fw_ff;
      end else begin
         if (ovf_pos)      diff_step = ACC_MAX;
         else if (ovf_neg) diff_step = ACC_MIN;
         else              diff_step = sum[ACC_BITS-1:0];
         fw_step = (fw_ff == '1) ? fw_ff : fw_ff + FW_BITS'(1);
      end
   end

   assign frame_empty = (pos_ff == '0) && (fw_ff == '0) && (part_ff == '0);

   // next state
   always_comb begin
      pos_in  = pos_ff;
      sign_in = sign_ff;
      diff_in = diff_ff;
      fw_in   = fw_ff;
      part_in = part_ff;
      if (accept) begin
         if (req_last_sample) begin
            pos_in  = '0;
            sign_in = cfg.start_sign;
            diff_in = '0;
            fw_in   = '0;
            part_in = '0;
         end else if (close_win) begin
            pos_in  = '0;
            sign_in = ~sign_ff;
            diff_in = diff_step;
            fw_in   = fw_step;
            part_in = '0;
         end else begin
            pos_in  = pos_ff + WINDOW_BITS'(1);
            part_in = part_add;
         end
      end else if (cfg.start_sign_wr && frame_empty) begin
         sign_in = cfg.start_sign;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         sign_ff <= cwdm_pkg::START_SIGN_RST;
         diff_ff <= '0;
         fw_ff   <= '0;
         part_ff <= '0;
      end else begin
         pos_ff  <= pos_in;
         sign_ff <= sign_in;
         diff_ff <= diff_in;
         fw_ff   <= fw_in;
         part_ff <= part_in;
      end
   end

   // frame record to the back end
   assign push_valid = accept && req_last_sample;
   assign push_data  = {diff_step, fw_step, v_eff};

endmodule

// ===== src/cwdm_back.sv =====
// ----------------------------------------------------------------------------
// cwdm_back: frame divider back end
// Pops a frame record, forms half the valid sample count with one multiply,
// divides the difference magnitude by it one quotient bit per cycle,
// restores the sign, saturates and holds the result word for the consumer (a zero divisor gives zero).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cwdm_back #(
   parameter int SAMPLE_BITS = 16,
   parameter int WINDOW_BITS = 8,
   parameter int FRAME_BITS  = 16
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        q_valid,
   input  logic [SAMPLE_BITS+FRAME_BITS+2+FRAME_BITS+1
                 +((WINDOW_BITS+1 > cwdm_pkg::CFG_BITS) ? WINDOW_BITS+1
                                                       : cwdm_pkg::CFG_BITS)-1:0]
                                                       q_data,
   output logic                                        q_pop,
   output logic                                        rsp_valid,
   input  logic                                        rsp_stall,
   output logic signed [SAMPLE_BITS+FRAME_BITS:0]      rsp_mean_diff,
   output logic                                        rsp_zero_divisor
);

   localparam int ACC_BITS  = SAMPLE_BITS + FRAME_BITS + 2;
   localparam int OUT_BITS  = SAMPLE_BITS + FRAME_BITS + 1;
   localparam int FW_BITS   = FRAME_BITS + 1;
   localparam int EW_BITS   = (WINDOW_BITS + 1 > cwdm_pkg::CFG_BITS) ? WINDOW_BITS + 1
                                                                    : cwdm_pkg::CFG_BITS;
   localparam int PROD_BITS = FW_BITS + EW_BITS;
   localparam int DIV_BITS  = PROD_BITS - 1;
   localparam int CNT_BITS  = $clog2(ACC_BITS);
   localparam logic [ACC_BITS-1:0] NEG_LIM = ACC_BITS'(1) << (OUT_BITS - 1);
   localparam logic signed [OUT_BITS-1:0] OUT_MAX = {1'b0, {(OUT_BITS-1){1'b1}}};
   localparam logic signed [OUT_BITS-1:0] OUT_MIN = {1'b1, {(OUT_BITS-1){1'b0}}};

   cwdm_pkg::cwdm_back_state_type state_ff, state_in;

   logic signed [ACC_BITS-1:0] diff_ff;
   logic [FW_BITS-1:0]         fw_ff;
   logic [EW_BITS-1:0]         v_ff;
   logic [PROD_BITS-1:0]       prod_ff;
   logic [ACC_BITS-1:0]        dvd_ff;
   logic [DIV_BITS-1:0]        rem_ff;
   logic [CNT_BITS-1:0]        cnt_ff;
   logic                       neg_ff;
   logic signed [OUT_BITS-1:0] mean_ff;
   logic                       zero_ff;

   logic [DIV_BITS-1:0]        half;
   logic [ACC_BITS-1:0]        mag;
   logic [DIV_BITS:0]          rem_sh, rem_sub;
   logic                       q_bit;
   logic [ACC_BITS-1:0]        q_neg;
   logic                       ovf_pos, ovf_neg;

   assign half    = prod_ff[PROD_BITS-1:1];
   assign mag     = diff_ff[ACC_BITS-1] ? ACC_BITS'(-diff_ff) : ACC_BITS'(diff_ff);
   assign rem_sh  = {rem_ff, dvd_ff[ACC_BITS-1]};
   assign rem_sub = rem_sh - {1'b0, half};
   assign q_bit   = (rem_sh >= {1'b0, half});
   assign q_neg   = -dvd_ff;
   assign ovf_pos = (dvd_ff[ACC_BITS-1:OUT_BITS-1] != '0);
   assign ovf_neg = (dvd_ff > NEG_LIM);

   // sequencer next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         cwdm_pkg::BK_IDLE: if (q_valid) state_in = cwdm_pkg::BK_MUL;
         cwdm_pkg::BK_MUL:  state_in = cwdm_pkg::BK_PREP;
         cwdm_pkg::BK_PREP: state_in = (half == '0) ? cwdm_pkg::BK_OUT : cwdm_pkg::BK_DIV;
         cwdm_pkg::BK_DIV:  if (cnt_ff == '0) state_in = cwdm_pkg::BK_SAT;
         cwdm_pkg::BK_SAT:  state_in = cwdm_pkg::BK_OUT;
         cwdm_pkg::BK_OUT:  if (!rsp_stall) state_in = cwdm_pkg::BK_IDLE;
         default:           state_in = cwdm_pkg::BK_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      q_pop     = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         cwdm_pkg::BK_IDLE: q_pop     = q_valid;
         cwdm_pkg::BK_OUT:  rsp_valid = 1'b1;
         default: begin
            q_pop     = 1'b0;
            rsp_valid = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= cwdm_pkg::BK_IDLE;
      else       state_ff <= state_in;
   end

   // datapath
   always_ff @(posedge clock) begin
      case (state_ff)
         cwdm_pkg::BK_IDLE: begin
            {diff_ff, fw_ff, v_ff} <= q_data;
         end
         cwdm_pkg::BK_MUL: begin
            prod_ff <= PROD_BITS'(fw_ff) * PROD_BITS'(v_ff);
         end
         cwdm_pkg::BK_PREP: begin
            dvd_ff  <= mag;
            rem_ff  <= '0;
            cnt_ff  <= CNT_BITS'(ACC_BITS - 1);
            neg_ff  <= diff_ff[ACC_BITS-1];
            mean_ff <= '0;
            zero_ff <= (half == '0);
         end
         cwdm_pkg::BK_DIV: begin
            // restoring step: one quotient bit into the dividend LSB
            rem_ff <= q_bit ? rem_sub[DIV_BITS-1:0] : rem_sh[DIV_BITS-1:0];
            dvd_ff <= {dvd_ff[ACC_BITS-2:0], q_bit};
            cnt_ff <= cnt_ff - CNT_BITS'(1);
         end
         cwdm_pkg::BK_SAT: begin
            if (neg_ff) mean_ff <= ovf_neg ? OUT_MIN : q_neg[OUT_BITS-1:0];
            else        mean_ff <= ovf_pos ? OUT_MAX : dvd_ff[OUT_BITS-1:0];
         end
         default: begin
            mean_ff <= mean_ff;
         end
      endcase
   end

   assign rsp_mean_diff    = mean_ff;
   assign rsp_zero_divisor = zero_ff;

endmodule

// ===== src/chopped_window_diff_mean.sv =====
// ----------------------------------------------------------------------------
// chopped_window_diff_mean: square-wave synchronous demodulator
// Takes one sample word per cycle while req_stall is low. Each frame record
// passes the frame queue, then back end states MUL, PREP, DIV and SAT; the result
// word is valid in OUT (a zero divisor skips DIV and SAT). The back end takes one
// frame at a time; a two-word queue absorbs short frames, then the input stalls.
// Synchronous active-high reset: window_len 4, valid_len 2, start_sign 0.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module chopped_window_diff_mean #(
   parameter int SAMPLE_BITS = 16,
   parameter int WINDOW_BITS = 8,
   parameter int FRAME_BITS  = 16
) (
   input  logic                                     clock,
   input  logic                                     reset,
   // sample input
   input  logic                                     req_valid,
   output logic                                     req_stall,
   input  logic signed [SAMPLE_BITS-1:0]            req_sample,
   input  logic                                     req_last_sample,
   // result output
   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output logic signed [SAMPLE_BITS+FRAME_BITS:0]   rsp_mean_diff,
   output logic                                     rsp_zero_divisor,
   // register writes
   input  logic                                     csr_valid,
   output logic                                     csr_ready,
   input  logic [cwdm_pkg::CSR_ADDR_BITS-1:0]       csr_addr,
   input  logic [cwdm_pkg::CFG_BITS-1:0]            csr_wdata
);

   localparam int EW_BITS  = (WINDOW_BITS + 1 > cwdm_pkg::CFG_BITS) ? WINDOW_BITS + 1
                                                                   : cwdm_pkg::CFG_BITS;
   localparam int REC_BITS = (SAMPLE_BITS + FRAME_BITS + 2) + (FRAME_BITS + 1) + EW_BITS;

   logic [cwdm_pkg::CFG_BITS-1:0] window_len_ff;
   logic [cwdm_pkg::CFG_BITS-1:0] valid_len_ff;
   logic                          start_sign_ff;
   logic                          csr_wr;
   cwdm_pkg::cwdm_cfg_type        cfg;

   logic                          push_valid;
   logic [REC_BITS-1:0]           push_data;
   logic                          q_full;
   logic                          q_pop;
   logic                          q_valid;
   logic [REC_BITS-1:0]           q_data;

   // register file
   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_len_ff <= cwdm_pkg::WINDOW_LEN_RST;
         valid_len_ff  <= cwdm_pkg::VALID_LEN_RST;
         start_sign_ff <= cwdm_pkg::START_SIGN_RST;
      end else if (csr_wr) begin
         unique case (csr_addr)
            cwdm_pkg::CSR_WINDOW_LEN: window_len_ff <= csr_wdata;
            cwdm_pkg::CSR_VALID_LEN:  valid_len_ff  <= csr_wdata;
            cwdm_pkg::CSR_START_SIGN: start_sign_ff <= csr_wdata[0];
            default:                  start_sign_ff <= start_sign_ff;
         endcase
      end
   end

   // start_sign reaches the front together with its write strobe
   always_comb begin
      cfg.window_len    = window_len_ff;
      cfg.valid_len     = valid_len_ff;
      cfg.start_sign    = start_sign_ff;
      cfg.start_sign_wr = 1'b0;
      if (csr_wr && (csr_addr == cwdm_pkg::CSR_START_SIGN)) begin
         cfg.start_sign    = csr_wdata[0];
         cfg.start_sign_wr = 1'b1;
      end
   end

   cwdm_front #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .WINDOW_BITS (WINDOW_BITS),
      .FRAME_BITS  (FRAME_BITS)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_sample      (req_sample),
      .req_last_sample (req_last_sample),
      .push_valid      (push_valid),
      .push_data       (push_data),
      .push_full       (q_full)
   );

   cwdm_queue #(
      .WIDTH (REC_BITS)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .full       (q_full),
      .pop        (q_pop),
      .pop_valid  (q_valid),
      .pop_data   (q_data)
   );

   cwdm_back #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .WINDOW_BITS (WINDOW_BITS),
      .FRAME_BITS  (FRAME_BITS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .q_valid          (q_valid),
      .q_data           (q_data),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_mean_diff    (rsp_mean_diff),
      .rsp_zero_divisor (rsp_zero_divisor)
   );

   // a frame record is never pushed into a full queue
   assert property (@(posedge clock) disable iff (reset) push_valid |-> !q_full)
      else $error("frame record pushed into full queue");

   // a zero divisor always comes with a zero mean
   assert property (@(posedge clock) disable iff (reset)
                    (rsp_valid && rsp_zero_divisor) |-> (rsp_mean_diff == '0))
      else $error("zero divisor word carries nonzero mean");

   // the back end pops only an occupied queue and never while presenting a word
   assert property (@(posedge clock) disable iff (reset) q_pop |-> (q_valid && !rsp_valid))
      else $error("queue popped while empty or while result pending");

endmodule
